[design/triaxial_moving_average_normalizer_core_defines.svh]
// Assertion macros shared by the triaxial normalizer modules.
// Depends on nothing; users must have clk and arst_n in scope.
`ifndef TRIAXIAL_MOVING_AVERAGE_NORMALIZER_CORE_DEFINES_SVH
`define TRIAXIAL_MOVING_AVERAGE_NORMALIZER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TMAN_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define TMAN_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/tman_pkg.sv]
// Shared constants, register indexes and lane interface types of the
// triaxial normalizer. No dependencies.
package tman_pkg;

	// Window length must stay a power of two: the mean is a right shift.
	localparam int WINDOW_LEN  = 8;
	localparam int SAMPLE_BITS = 10;
	localparam int PTR_W       = $clog2(WINDOW_LEN);
	localparam int SUM_W       = SAMPLE_BITS + PTR_W;
	localparam int BOUND_W     = 10;
	localparam int MEAN_W      = 10;
	localparam int SCALE_SHIFT = 3;
	localparam int Q_W         = SCALE_SHIFT + 1;
	localparam int NUM_W       = BOUND_W + SCALE_SHIFT;
	localparam int STEP_W      = $clog2(Q_W);
	localparam int CFG_IDX_W   = 3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_X_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_X_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_Y_LOW  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Y_HIGH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_Z_LOW  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_Z_HIGH = 3'd5;

	typedef struct packed {
		logic start;
		logic ack;
	} lane_ctrl_t;

	typedef struct packed {
		logic idle;
		logic done;
	} lane_stat_t;

	typedef struct packed {
		logic [MEAN_W-1:0] mean;
		logic [Q_W-1:0]    scaled;
		logic              err;
	} lane_res_t;

endpackage

[design/tman_lane.sv]
// One axis lane: sample ring, running total, clamp and 4-step range divider.
// Depends on tman_pkg and the assertion macro header.
`include "triaxial_moving_average_normalizer_core_defines.svh"

module tman_lane (
	input  logic                           clk,
	input  logic                           arst_n,
	input  tman_pkg::lane_ctrl_t           ctrl,
	input  logic [tman_pkg::PTR_W-1:0]     slot,
	input  logic [tman_pkg::SAMPLE_BITS-1:0] sample,
	input  logic [tman_pkg::BOUND_W-1:0]   low,
	input  logic [tman_pkg::BOUND_W-1:0]   high,
	output tman_pkg::lane_stat_t           stat,
	output tman_pkg::lane_res_t            res
);
	import tman_pkg::*;

	localparam logic [1:0] L_IDLE  = 2'd0;
	localparam logic [1:0] L_CLAMP = 2'd1;
	localparam logic [1:0] L_DIV   = 2'd2;
	localparam logic [1:0] L_DONE  = 2'd3;

	logic [1:0]             state_q;
	logic [SAMPLE_BITS-1:0] ring_q [WINDOW_LEN];
	logic [SUM_W-1:0]       total_q;
	logic [STEP_W-1:0]      step_q;
	logic [MEAN_W-1:0]      mean_q;
	logic                   err_q;
	logic [NUM_W-1:0]       rem_q;
	logic [NUM_W-1:0]       dv_q;
	logic [Q_W-1:0]         quot_q;

	logic [MEAN_W-1:0]      mean_c;
	logic [BOUND_W-1:0]     clamp_c;
	logic [BOUND_W-1:0]     diff_c;
	logic                   ge_c;

	// Clamp the fresh mean into the bounds and take its offset from low
	always_comb begin
		mean_c = MEAN_W'(total_q >> PTR_W);
		if (mean_c < low) begin
			clamp_c = low;
		end else if (mean_c > high) begin
			clamp_c = high;
		end else begin
			clamp_c = mean_c;
		end
		diff_c = clamp_c - low;
		ge_c   = (rem_q >= dv_q);
	end

	// Replace the slot sample and adjust the running total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_LEN; i++) begin
				ring_q[i] <= '0;
			end
			total_q <= '0;
		end else if (ctrl.start) begin
			ring_q[slot] <= sample;
			total_q      <= total_q - SUM_W'(ring_q[slot]) + SUM_W'(sample);
		end
	end

	// Sequence clamp, divide and hold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				L_IDLE: begin
					if (ctrl.start) begin
						state_q <= L_CLAMP;
					end
				end
				L_CLAMP: begin
					state_q <= L_DIV;
					step_q  <= STEP_W'(Q_W - 1);
				end
				L_DIV: begin
					step_q <= step_q - 1'b1;
					if (step_q == '0) begin
						state_q <= L_DONE;
					end
				end
				L_DONE: begin
					if (ctrl.ack) begin
						state_q <= L_IDLE;
					end
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

	// Restoring divide, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (state_q == L_CLAMP) begin
			mean_q <= mean_c;
			err_q  <= (high <= low);
			rem_q  <= {diff_c, SCALE_SHIFT'(0)};
			dv_q   <= NUM_W'(high - low) << (Q_W - 1);
			quot_q <= '0;
		end else if (state_q == L_DIV) begin
			if (ge_c) begin
				rem_q <= rem_q - dv_q;
			end
			quot_q <= {quot_q[Q_W-2:0], ge_c};
			dv_q   <= dv_q >> 1;
		end
	end

	assign stat.idle  = (state_q == L_IDLE);
	assign stat.done  = (state_q == L_DONE);
	assign res.mean   = mean_q;
	assign res.scaled = err_q ? '0 : quot_q;
	assign res.err    = err_q;

	`TMAN_ASSERT_NOW(a_start_idle, ctrl.start, state_q == L_IDLE, "lane started while busy")
	`TMAN_ASSERT_NOW(a_ack_done, ctrl.ack, state_q == L_DONE, "lane released before done")
	`TMAN_ASSERT_NOW(a_quot_range, state_q == L_DONE && !err_q, quot_q <= Q_W'(1 << SCALE_SHIFT),
		"scaled value above full scale")
	`TMAN_ASSERT_NEXT(a_clamp_div, state_q == L_CLAMP, state_q == L_DIV, "divide did not follow clamp")

endmodule

[design/tman_merge.sv]
// Merge stage: collects the three lane results into the output register
// and ORs the bound errors. Depends on tman_pkg.
module tman_merge (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  tman_pkg::lane_res_t           res_x,
	input  tman_pkg::lane_res_t           res_y,
	input  tman_pkg::lane_res_t           res_z,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [tman_pkg::MEAN_W-1:0]   mean_x,
	output logic [tman_pkg::MEAN_W-1:0]   mean_y,
	output logic [tman_pkg::MEAN_W-1:0]   mean_z,
	output logic [tman_pkg::Q_W-1:0]      scaled_x,
	output logic [tman_pkg::Q_W-1:0]      scaled_y,
	output logic [tman_pkg::Q_W-1:0]      scaled_z,
	output logic                          bound_error
);
	import tman_pkg::*;

	logic valid_q;

	// Hold the result valid until taken; a load refills it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// Capture the lane results
	always_ff @(posedge clk) begin
		if (load) begin
			mean_x      <= res_x.mean;
			mean_y      <= res_y.mean;
			mean_z      <= res_z.mean;
			scaled_x    <= res_x.scaled;
			scaled_y    <= res_y.scaled;
			scaled_z    <= res_z.scaled;
			bound_error <= res_x.err | res_y.err | res_z.err;
		end
	end

	assign out_valid = valid_q;

endmodule

[design/triaxial_moving_average_normalizer_core.sv]
// Top level of the triaxial moving-average normalizer: bound registers,
// slot pointer, control, three tman_lane instances and tman_merge.
// Depends on tman_pkg, tman_lane, tman_merge and the assertion macro header.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   input   | in_valid/in_ready, sample_x/y/z           | in
//   output  | out_valid/out_ready, mean_*, scaled_*,    | out
//           | bound_error                               |
//   config  | cfg_we, cfg_index, cfg_data               | in
//
// Each request passes through the ring update, the clamp, the restoring divider (one
// quotient bit per step) and the load of the output register before the next is
// accepted. The output register frees the lanes, so a new request is taken while a
// result waits; a stalled output holds the lanes in their done state. Reset clears
// the rings, totals, pointer and control, and sets each low bound to zero and each
// high bound to all ones.
`include "triaxial_moving_average_normalizer_core_defines.svh"

module triaxial_moving_average_normalizer_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [tman_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tman_pkg::BOUND_W-1:0]      cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [tman_pkg::SAMPLE_BITS-1:0]  sample_x,
	input  logic [tman_pkg::SAMPLE_BITS-1:0]  sample_y,
	input  logic [tman_pkg::SAMPLE_BITS-1:0]  sample_z,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [tman_pkg::MEAN_W-1:0]       mean_x,
	output logic [tman_pkg::MEAN_W-1:0]       mean_y,
	output logic [tman_pkg::MEAN_W-1:0]       mean_z,
	output logic [tman_pkg::Q_W-1:0]          scaled_x,
	output logic [tman_pkg::Q_W-1:0]          scaled_y,
	output logic [tman_pkg::Q_W-1:0]          scaled_z,
	output logic                              bound_error
);
	import tman_pkg::*;

	logic [BOUND_W-1:0] x_low_q, x_high_q, y_low_q, y_high_q, z_low_q, z_high_q;
	logic [PTR_W-1:0]   slot_q;
	logic               busy_q;
	logic               accept;
	logic               all_done;
	logic               load;
	lane_ctrl_t         ctrl;
	lane_stat_t         stat_x, stat_y, stat_z;
	lane_res_t          res_x, res_y, res_z;

	assign in_ready = !busy_q;
	assign accept   = in_valid && in_ready;
	assign all_done = stat_x.done && stat_y.done && stat_z.done;
	assign load     = busy_q && all_done && (!out_valid || out_ready);

	assign ctrl.start = accept;
	assign ctrl.ack   = load;

	// Write bound registers; drop unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_low_q  <= '0;
			x_high_q <= '1;
			y_low_q  <= '0;
			y_high_q <= '1;
			z_low_q  <= '0;
			z_high_q <= '1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_X_LOW:  x_low_q  <= cfg_data;
				REG_X_HIGH: x_high_q <= cfg_data;
				REG_Y_LOW:  y_low_q  <= cfg_data;
				REG_Y_HIGH: y_high_q <= cfg_data;
				REG_Z_LOW:  z_low_q  <= cfg_data;
				REG_Z_HIGH: z_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance the slot pointer and track the request in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			busy_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
				if (slot_q == PTR_W'(WINDOW_LEN - 1)) begin
					slot_q <= '0;
				end else begin
					slot_q <= slot_q + 1'b1;
				end
			end else if (load) begin
				busy_q <= 1'b0;
			end
		end
	end

	tman_lane u_lane_x (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.slot   (slot_q),
		.sample (sample_x),
		.low    (x_low_q),
		.high   (x_high_q),
		.stat   (stat_x),
		.res    (res_x)
	);

	tman_lane u_lane_y (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.slot   (slot_q),
		.sample (sample_y),
		.low    (y_low_q),
		.high   (y_high_q),
		.stat   (stat_y),
		.res    (res_y)
	);

	tman_lane u_lane_z (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.slot   (slot_q),
		.sample (sample_z),
		.low    (z_low_q),
		.high   (z_high_q),
		.stat   (stat_z),
		.res    (res_z)
	);

	tman_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (load),
		.res_x       (res_x),
		.res_y       (res_y),
		.res_z       (res_z),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.mean_x      (mean_x),
		.mean_y      (mean_y),
		.mean_z      (mean_z),
		.scaled_x    (scaled_x),
		.scaled_y    (scaled_y),
		.scaled_z    (scaled_z),
		.bound_error (bound_error)
	);

	`TMAN_ASSERT_NOW(a_accept_idle, accept, stat_x.idle && stat_y.idle && stat_z.idle,
		"request accepted while lanes busy")
	`TMAN_ASSERT_NOW(a_lanes_lockstep, busy_q, stat_x.done == stat_y.done && stat_y.done == stat_z.done,
		"lanes out of step")
	`TMAN_ASSERT_NEXT(a_accept_busy, accept, busy_q, "accepted request not tracked")
	`TMAN_ASSERT_NEXT(a_load_valid, load, out_valid, "loaded result not presented")

endmodule

[test/triaxial_moving_average_normalizer_core_tb.sv]
// Self-checking bench for triaxial_moving_average_normalizer_core: keeps its own copy of
// the sample windows and bound registers, predicts every result and checks each field.
// Depends on tman_pkg and the core RTL.
module triaxial_moving_average_normalizer_core_tb;
	import tman_pkg::*;

	// Indexes past the last bound register; writes there must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
	localparam int LONG_HOLD    = 400;
	localparam int MAX_PRINTS   = 40;
	localparam int RAND_PHASES  = 10;
	localparam int PHASE_LEN    = 83;
	localparam int SAMPLE_MAX   = (1 << SAMPLE_BITS) - 1;
	localparam int BOUND_MAX    = (1 << BOUND_W) - 1;

	typedef logic [2:0][SAMPLE_BITS-1:0] triple_t;
	typedef struct packed {
		logic [2:0][MEAN_W-1:0] mean;
		logic [2:0][Q_W-1:0]    scaled;
		logic                   bound_error;
	} norm_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [BOUND_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [SAMPLE_BITS-1:0] sample_x = '0;
	logic [SAMPLE_BITS-1:0] sample_y = '0;
	logic [SAMPLE_BITS-1:0] sample_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [MEAN_W-1:0] mean_x, mean_y, mean_z;
	logic [Q_W-1:0] scaled_x, scaled_y, scaled_z;
	logic bound_error;

	// Window model state and mirrored bound registers
	logic [SAMPLE_BITS-1:0] window_ring [3][WINDOW_LEN];
	logic [SUM_W-1:0] window_total [3];
	logic [PTR_W-1:0] window_slot;
	logic [BOUND_W-1:0] low_bound [3];
	logic [BOUND_W-1:0] high_bound [3];

	triple_t pending_requests [$];
	norm_result_t expected_results [$];
	triple_t next_req;
	string lane_tag [3] = '{"x", "y", "z"};

	int mismatches = 0;
	int accepted = 0;
	int checked = 0;
	int fault_results = 0;
	int cfg_writes = 0;
	int held_cycles = 0;
	int idle_left = 0;
	int stall_left = 0;
	int hold_left = 0;
	int hold_req = 0;
	int hold_seen = 0;
	logic steady_flow = 1'b0;

	triaxial_moving_average_normalizer_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample_x(sample_x),
		.sample_y(sample_y),
		.sample_z(sample_z),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.mean_x(mean_x),
		.mean_y(mean_y),
		.mean_z(mean_z),
		.scaled_x(scaled_x),
		.scaled_y(scaled_y),
		.scaled_z(scaled_z),
		.bound_error(bound_error)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= MAX_PRINTS)
			$display("MISMATCH at %0t: %s", $time, what);
	endtask

	// Mostly short gaps, now and then a long one
	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Push one request through the window model and scale the new means
	function automatic norm_result_t advance_window(input triple_t s);
		norm_result_t r;
		int a, m, lo, hi;
		r = '0;
		for (a = 0; a < 3; a++) begin
			window_total[a] = window_total[a] - SUM_W'(window_ring[a][window_slot])
				+ SUM_W'(s[a]);
			window_ring[a][window_slot] = s[a];
			m = int'(window_total[a]) / WINDOW_LEN;
			r.mean[a] = MEAN_W'(m);
			lo = int'(low_bound[a]);
			hi = int'(high_bound[a]);
			if (hi <= lo) begin
				r.bound_error = 1'b1;
				r.scaled[a] = '0;
			end else begin
				if (m < lo) m = lo;
				if (m > hi) m = hi;
				r.scaled[a] = Q_W'(((m - lo) << SCALE_SHIFT) / (hi - lo));
			end
		end
		if (window_slot == PTR_W'(WINDOW_LEN - 1)) window_slot = '0;
		else window_slot = window_slot + 1'b1;
		return r;
	endfunction

	// Track a register write in the mirrored bounds
	function automatic void mirror_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [BOUND_W-1:0] val);
		case (idx)
			REG_X_LOW:  low_bound[0] = val;
			REG_X_HIGH: high_bound[0] = val;
			REG_Y_LOW:  low_bound[1] = val;
			REG_Y_HIGH: high_bound[1] = val;
			REG_Z_LOW:  low_bound[2] = val;
			REG_Z_HIGH: high_bound[2] = val;
			default: ;
		endcase
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BOUND_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		mirror_write(idx, val);
		cfg_writes++;
	endtask

	// Write all six bounds, optionally poking the unused indexes too
	task automatic set_bounds(input logic [2:0][BOUND_W-1:0] lo,
			input logic [2:0][BOUND_W-1:0] hi, input bit poke_spare);
		write_reg(REG_X_LOW, lo[0]);
		write_reg(REG_X_HIGH, hi[0]);
		write_reg(REG_Y_LOW, lo[1]);
		write_reg(REG_Y_HIGH, hi[1]);
		write_reg(REG_Z_LOW, lo[2]);
		write_reg(REG_Z_HIGH, hi[2]);
		if (poke_spare) begin
			write_reg(REG_SPARE_6, BOUND_W'(BOUND_MAX));
			write_reg(REG_SPARE_7, 10'd1);
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic randomize_bounds();
		logic [2:0][BOUND_W-1:0] lo, hi;
		int a, l;
		for (a = 0; a < 3; a++) begin
			case ($urandom_range(0, 9))
				0: begin
					lo[a] = '0;
					hi[a] = BOUND_W'(BOUND_MAX);
				end
				1: begin
					l = $urandom_range(1, BOUND_MAX);
					lo[a] = BOUND_W'(l);
					hi[a] = BOUND_W'($urandom_range(0, l - 1));
				end
				2: begin
					l = $urandom_range(0, BOUND_MAX);
					lo[a] = BOUND_W'(l);
					hi[a] = BOUND_W'(l);
				end
				3: begin
					l = $urandom_range(0, BOUND_MAX - 1);
					lo[a] = BOUND_W'(l);
					hi[a] = BOUND_W'($urandom_range(l + 1, BOUND_MAX));
				end
				4, 5: begin
					l = $urandom_range(0, BOUND_MAX - 8);
					lo[a] = BOUND_W'(l);
					hi[a] = BOUND_W'(l + $urandom_range(1, 8));
				end
				default: begin
					l = $urandom_range(0, 600);
					lo[a] = BOUND_W'(l);
					hi[a] = BOUND_W'(l + $urandom_range(50, BOUND_MAX - l));
				end
			endcase
		end
		set_bounds(lo, hi, 1'b0);
	endtask

	// Pick a level for an axis: rails, bounds, their midpoint or anywhere
	function automatic int pick_center(input int a);
		case ($urandom_range(0, 6))
			0: return 0;
			1: return SAMPLE_MAX;
			2, 3: return $urandom_range(0, SAMPLE_MAX);
			4: return int'(low_bound[a]);
			5: return int'(high_bound[a]);
			default: return (int'(low_bound[a]) + int'(high_bound[a])) / 2;
		endcase
	endfunction

	// Slowly wandering levels with noise, plus some fully random requests
	task automatic queue_random_requests(input int count);
		int center [3];
		int a, k, v;
		triple_t t;
		for (a = 0; a < 3; a++) center[a] = pick_center(a);
		for (k = 0; k < count; k++) begin
			if ($urandom_range(0, 15) == 0)
				for (a = 0; a < 3; a++) center[a] = pick_center(a);
			for (a = 0; a < 3; a++) begin
				if ($urandom_range(0, 6) == 0) v = $urandom_range(0, SAMPLE_MAX);
				else v = center[a] + int'($urandom_range(0, 40)) - 20;
				if (v < 0) v = 0;
				if (v > SAMPLE_MAX) v = SAMPLE_MAX;
				t[a] = SAMPLE_BITS'(v);
			end
			pending_requests.push_back(t);
		end
	endtask

	task automatic push_triple(input int x, input int y, input int z);
		triple_t t;
		t[0] = SAMPLE_BITS'(x);
		t[1] = SAMPLE_BITS'(y);
		t[2] = SAMPLE_BITS'(z);
		pending_requests.push_back(t);
	endtask

	// Let the sender drain and every result arrive
	task automatic wait_idle();
		do @(negedge clk);
		while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic check_result();
		norm_result_t want, got;
		int a;
		got.mean = {mean_z, mean_y, mean_x};
		got.scaled = {scaled_z, scaled_y, scaled_x};
		got.bound_error = bound_error;
		checked++;
		if (got.bound_error) fault_results++;
		if (expected_results.size() == 0) begin
			report_mismatch($sformatf("result with no request outstanding, means %0d %0d %0d",
				mean_x, mean_y, mean_z));
			return;
		end
		want = expected_results.pop_front();
		for (a = 0; a < 3; a++) begin
			if (got.mean[a] !== want.mean[a])
				report_mismatch($sformatf("mean_%s got %0d want %0d",
					lane_tag[a], got.mean[a], want.mean[a]));
			if (got.scaled[a] !== want.scaled[a])
				report_mismatch($sformatf("scaled_%s got %0d want %0d",
					lane_tag[a], got.scaled[a], want.scaled[a]));
		end
		if (got.bound_error !== want.bound_error)
			report_mismatch($sformatf("bound_error got %0b want %0b",
				got.bound_error, want.bound_error));
	endtask

	// Sender: log accepted requests, then offer the next one after its gap
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			sample_x <= '0;
			sample_y <= '0;
			sample_z <= '0;
			idle_left <= 0;
		end else begin
			if (in_valid && in_ready) begin
				expected_results.push_back(advance_window({sample_z, sample_y, sample_x}));
				accepted++;
			end
			if (!in_valid || in_ready) begin
				if (idle_left > 0) begin
					in_valid <= 1'b0;
					idle_left <= idle_left - 1;
				end else if (pending_requests.size() != 0) begin
					next_req = pending_requests.pop_front();
					in_valid <= 1'b1;
					sample_x <= next_req[0];
					sample_y <= next_req[1];
					sample_z <= next_req[2];
					idle_left <= steady_flow ? 0 : draw_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: check each result, stall at random, hold off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
			hold_left <= 0;
			hold_seen <= 0;
		end else begin
			if (out_valid && out_ready) check_result();
			if (hold_req != hold_seen) begin
				hold_seen <= hold_req;
				hold_left <= LONG_HOLD;
				out_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				held_cycles++;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_ready <= 1'b0;
			end else if (!steady_flow && $urandom_range(0, 3) == 0) begin
				stall_left <= draw_gap();
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		int a, i, phase;
		for (a = 0; a < 3; a++) begin
			for (i = 0; i < WINDOW_LEN; i++) window_ring[a][i] = '0;
			window_total[a] = '0;
			low_bound[a] = '0;
			high_bound[a] = BOUND_W'(BOUND_MAX);
		end
		window_slot = '0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Default bounds: climb to full scale, alternating bit patterns, fall back
		push_triple(0, 0, 0);
		for (i = 0; i < WINDOW_LEN; i++) push_triple(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
		push_triple('h2AA, 'h155, SAMPLE_MAX);
		push_triple('h155, 'h2AA, 0);
		for (i = 0; i < 3; i++) push_triple(0, 0, 0);
		wait_idle();

		// Ordered x, equal y, inverted z; spare indexes must be ignored
		set_bounds({10'd900, 10'd500, 10'd100}, {10'd100, 10'd500, 10'd900}, 1'b1);
		for (i = 0; i < 4; i++) push_triple(0, 0, 0);
		for (i = 0; i < 6; i++) push_triple(SAMPLE_MAX, 700, 300);
		wait_idle();

		for (phase = 0; phase < RAND_PHASES; phase++) begin
			steady_flow = (phase == 0) || (phase == 3);
			if (phase == 1)
				set_bounds({10'd0, 10'd1022, 10'd0}, {10'd1023, 10'd1023, 10'd1}, 1'b0);
			else
				randomize_bounds();
			queue_random_requests(PHASE_LEN);
			// Stall the output long enough for the core to back up its input
			if (phase == 3) begin
				repeat (5) @(posedge clk);
				hold_req <= hold_req + 1;
			end
			wait_idle();
		end

		repeat (20) @(negedge clk);
		while (expected_results.size() != 0) begin
			void'(expected_results.pop_front());
			report_mismatch("expected result never arrived");
		end
		$display("Covered %0d requests and %0d results over %0d bound register writes,",
			accepted, checked, cfg_writes);
		$display("%0d results flagged a bound fault; receiver held off %0d cycles in one stretch",
			fault_results, held_cycles);
		if (mismatches == 0) begin
			$display("triaxial_moving_average_normalizer_core regression: pass");
		end else begin
			$display("triaxial_moving_average_normalizer_core regression: fail");
		end
		$finish;
	end

	initial begin
		#12000000;
		$display("triaxial_moving_average_normalizer_core regression: fail");
		$finish;
	end

endmodule

[sim.f]
+incdir+design
design/tman_pkg.sv
design/tman_lane.sv
design/tman_merge.sv
design/triaxial_moving_average_normalizer_core.sv
test/triaxial_moving_average_normalizer_core_tb.sv
